[rtl/itoa_pkg.sv]
package itoa_pkg;

   // Field widths of the two channels
   localparam int VALUE_FIELD_BITS = 32;
   localparam int RADIX_BITS       = 5;
   localparam int FLAGS_BITS       = 2;
   localparam int CHAR_BITS        = 8;

   // Converted width; bits of the value field above it are ignored
   localparam int VALUE_BITS = 32;
   localparam int EXT_BITS   = (VALUE_BITS > VALUE_FIELD_BITS) ? VALUE_BITS : VALUE_FIELD_BITS;

   // One digit is at most 15
   localparam int DIGIT_BITS = 4;

   // Divider: DIV_CHUNK quotient bits per cycle
   localparam int DIV_CHUNK  = 8;
   localparam int DIV_CYCLES = (VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
   localparam int DIV_BITS   = DIV_CYCLES * DIV_CHUNK;
   localparam int STEP_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   // Digit store: radix 2 gives at most VALUE_BITS digits
   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int IDX_BITS = $clog2(VALUE_BITS);

   // Format flag positions
   localparam int FLAG_UNSIGNED_BIT = 0;
   localparam int FLAG_LOWER_BIT    = 1;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN  = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX  = RADIX_BITS'(16);
   localparam logic [CHAR_BITS-1:0]  MINUS_CHAR = 8'h2D;
   localparam logic [CHAR_BITS-1:0]  ZERO_CHAR  = 8'h30;
   localparam logic [CHAR_BITS-1:0]  UPPER_A    = 8'h41;
   localparam logic [CHAR_BITS-1:0]  LOWER_A    = 8'h61;

   typedef struct packed {
      logic [DIV_CHUNK-1:0]  quot;
      logic [DIGIT_BITS-1:0] rem;
   } div_out_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                                       input logic lower);
      logic [CHAR_BITS-1:0] d_ext;
      d_ext = CHAR_BITS'(d);
      if (d < DIGIT_BITS'(10)) begin
         return ZERO_CHAR + d_ext;
      end else if (lower) begin
         return LOWER_A + d_ext - CHAR_BITS'(10);
      end else begin
         return UPPER_A + d_ext - CHAR_BITS'(10);
      end
   endfunction

endpackage

[rtl/itoa_intf.sv]
interface itoa_req_if import itoa_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [VALUE_FIELD_BITS-1:0] value;
   logic [RADIX_BITS-1:0]       radix;
   logic [FLAGS_BITS-1:0]       format_flags;

   modport source (output valid, output value, output radix, output format_flags,
                   input ready);
   modport sink   (input valid, input value, input radix, input format_flags,
                   output ready);
endinterface

interface itoa_rsp_if import itoa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_out;
   logic                 last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

[rtl/integer_to_ascii_base_n_unit.sv]
// Integer to ASCII text, radix 2 to 16. A request beat carries a value, a radix
// (0 and 1 act as 2, 17 to 31 as 16) and two flags: bit 0 converts the raw pattern
// as unsigned, else a negative value is negated and led by '-'; bit 1 picks a-f
// over A-F. The response is one beat per character, most significant first, with
// last set on the final digit; zero gives a single '0'. One request at a time:
// req ready is high only while the unit is idle. Each digit is worked out in the
// shared divider, which takes 8 quotient bits a cycle; each character is then
// read from the digit store and loaded into the output register, which waits out
// any response stall; a negative number has its sign loaded first.
module integer_to_ascii_base_n_unit import itoa_pkg::*; (
   input logic         clock,
   input logic         reset,
   itoa_req_if.sink    req_chan,
   itoa_rsp_if.source  rsp_chan
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_PUT   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [CNT_BITS-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [DIV_BITS-1:0]   div_ff, div_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic                  neg_ff, neg_in;
   logic                  lower_ff, lower_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [DIGIT_BITS-1:0] rd_ff;

   // Digit store, least significant digit at address 0
   logic [DIGIT_BITS-1:0] dig_mem [VALUE_BITS];
   logic                  mem_we;
   logic                  mem_re;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [CNT_BITS-1:0]   top_idx;

   logic [EXT_BITS-1:0]   value_ext;
   logic [VALUE_BITS-1:0] value_raw;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  req_neg;
   logic [RADIX_BITS-1:0] req_radix;

   div_out_type           div_out;
   logic [DIV_BITS-1:0]   div_next;
   logic                  slot_free;
   logic                  req_fire;

   // ---- request decode ----
   assign value_ext = EXT_BITS'(req_chan.value);
   assign value_raw = value_ext[VALUE_BITS-1:0];
   assign req_neg   = !req_chan.format_flags[FLAG_UNSIGNED_BIT] && value_raw[VALUE_BITS-1];
   // two's complement magnitude; the most negative value maps onto 2^(VALUE_BITS-1)
   assign magnitude = req_neg ? VALUE_BITS'(~value_raw + 1'b1) : value_raw;

   always_comb begin
      priority if (req_chan.radix < RADIX_MIN) begin
         req_radix = RADIX_MIN;
      end else if (req_chan.radix > RADIX_MAX) begin
         req_radix = RADIX_MAX;
      end else begin
         req_radix = req_chan.radix;
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // ---- shared divider: top chunk of the dividend each cycle ----
   itoa_div_step u_div_step (
      .partial_rem (rem_ff),
      .chunk       (div_ff[DIV_BITS-1 -: DIV_CHUNK]),
      .radix       (radix_ff),
      .result      (div_out)
   );

   // quotient bits shift in at the bottom; once every chunk has passed, the word is the quotient
   assign div_next = (div_ff << DIV_CHUNK) | DIV_BITS'(div_out.quot);

   // ---- output register ----
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign top_idx = dig_cnt_ff - 1'b1;
   assign wr_addr = dig_cnt_ff[IDX_BITS-1:0];
   assign rd_addr = top_idx[IDX_BITS-1:0];

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      dig_cnt_in   = dig_cnt_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      lower_in     = lower_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               div_in     = DIV_BITS'(magnitude);
               rem_in     = '0;
               step_in    = '0;
               dig_cnt_in = '0;
               radix_in   = req_radix;
               neg_in     = req_neg;
               lower_in   = req_chan.format_flags[FLAG_LOWER_BIT];
               state_in   = ST_DIV;
            end
         end

         ST_DIV: begin
            div_in  = div_next;
            rem_in  = div_out.rem;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIV_CYCLES - 1)) begin
               // digit done: store remainder, restart on the quotient
               mem_we     = 1'b1;
               dig_cnt_in = dig_cnt_ff + 1'b1;
               rem_in     = '0;
               step_in    = '0;
               if (div_next == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_FETCH;
               end
            end
         end

         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = MINUS_CHAR;
               rsp_last_in  = 1'b0;
               state_in     = ST_FETCH;
            end
         end

         ST_FETCH: begin
            mem_re   = 1'b1;
            state_in = ST_PUT;
         end

         ST_PUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(rd_ff, lower_ff);
               rsp_last_in  = (dig_cnt_ff == CNT_BITS'(1));
               dig_cnt_in   = top_idx;
               state_in     = (dig_cnt_ff == CNT_BITS'(1)) ? ST_IDLE : ST_FETCH;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         dig_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dig_cnt_ff   <= dig_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      neg_ff      <= neg_in;
      lower_ff    <= lower_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---- digit store ----
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dig_mem[wr_addr] <= div_out.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= dig_mem[rd_addr];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.char_out = rsp_char_ff;
   assign rsp_chan.last     = rsp_last_ff;

`ifndef ASSERT_OFF
   // the sign never closes a number
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_char_ff != MINUS_CHAR)
      else $error("sign beat marked last");

   // running remainder must stay below the radix
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < radix_ff)
      else $error("divider remainder out of range");

   // emission only with digits left in the store
   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH || state_ff == ST_PUT || state_ff == ST_SIGN
         |-> dig_cnt_ff != '0)
      else $error("emitting with empty digit store");

   // a finished number returns to idle only after its last beat is loaded
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUT && state_in == ST_IDLE |=> rsp_valid_ff && rsp_last_ff)
      else $error("returned to idle without last beat");
`endif

endmodule

[rtl/itoa_div_step.sv]
// DIV_CHUNK restoring division steps by a small radix.
module itoa_div_step import itoa_pkg::*; (
   input  logic [DIGIT_BITS-1:0] partial_rem,
   input  logic [DIV_CHUNK-1:0]  chunk,
   input  logic [RADIX_BITS-1:0] radix,
   output div_out_type           result
);

   always_comb begin
      logic [RADIX_BITS-1:0] trial;
      logic [DIGIT_BITS-1:0] r;
      logic [DIV_CHUNK-1:0]  q;
      r = partial_rem;
      q = '0;
      for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
         trial = {r, chunk[i]};
         if (trial >= radix) begin
            trial = trial - radix;
            q[i]  = 1'b1;
         end
         // remainder stays below radix, so it fits in a digit
         r = trial[DIGIT_BITS-1:0];
      end
      result.quot = q;
      result.rem  = r;
   end

endmodule

[tb/sv/testbench.sv]
module testbench import itoa_pkg::*; ();

   // Format flag settings, bit 0 raw unsigned, bit 1 lowercase letters
   localparam logic [FLAGS_BITS-1:0] FMT_SIGNED_UPPER   = 2'b00;
   localparam logic [FLAGS_BITS-1:0] FMT_UNSIGNED_UPPER = 2'b01;
   localparam logic [FLAGS_BITS-1:0] FMT_SIGNED_LOWER   = 2'b10;
   localparam logic [FLAGS_BITS-1:0] FMT_UNSIGNED_LOWER = 2'b11;

   // Budget for ~250 numbers with full stalls plus hold-offs
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_NUMBERS = 25;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_CAP    = 40;

   // Expected text store and checker. Each accepted number is turned into its
   // characters up front; every response beat is then matched against the oldest.
   class text_scoreboard;
      typedef struct packed {
         logic [CHAR_BITS-1:0] ch;
         logic                 last;
      } char_beat_type;

      char_beat_type awaited[$];
      int mismatches;
      int numbers_noted;
      int chars_checked;
      int negatives_noted;
      int longest_text;

      function void note_request(logic [VALUE_FIELD_BITS-1:0] value,
                                 logic [RADIX_BITS-1:0] radix,
                                 logic [FLAGS_BITS-1:0] flags);
         logic [63:0]          width_mask;
         logic [63:0]          magnitude;
         logic [63:0]          base;
         logic                 negative;
         string                digit_set;
         logic [CHAR_BITS-1:0] digit_chars[$];
         char_beat_type        beat;
         width_mask = (64'd1 << VALUE_BITS) - 64'd1;
         magnitude  = 64'(value) & width_mask;
         base       = 64'(radix);
         // out-of-range radices clamp to the nearest legal one
         if (base < 64'd2) begin
            base = 64'd2;
         end else if (base > 64'd16) begin
            base = 64'd16;
         end
         if (flags[FLAG_LOWER_BIT]) begin
            digit_set = "0123456789abcdef";
         end else begin
            digit_set = "0123456789ABCDEF";
         end
         negative = !flags[FLAG_UNSIGNED_BIT] && magnitude[VALUE_BITS-1];
         // two's complement negate in 64 bits, so the most negative value is exact
         if (negative) begin
            magnitude = (64'd0 - magnitude) & width_mask;
         end
         do begin
            digit_chars.push_front(digit_set[int'(magnitude % base)]);
            magnitude = magnitude / base;
         end while (magnitude != 64'd0);
         if (negative) begin
            beat.ch   = MINUS_CHAR;
            beat.last = 1'b0;
            awaited.push_back(beat);
            negatives_noted++;
         end
         foreach (digit_chars[i]) begin
            beat.ch   = digit_chars[i];
            beat.last = (i == digit_chars.size() - 1);
            awaited.push_back(beat);
         end
         if (digit_chars.size() + int'(negative) > longest_text) begin
            longest_text = digit_chars.size() + int'(negative);
         end
         numbers_noted++;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= REPORT_CAP) begin
            $display("MISMATCH at %0t: %s", $time, what);
         end
      endtask

      task check_char(logic [CHAR_BITS-1:0] ch, logic last);
         char_beat_type want;
         chars_checked++;
         if (awaited.size() == 0) begin
            report($sformatf("character 8'h%02h last %0b with no number pending", ch, last));
            return;
         end
         want = awaited.pop_front();
         if (ch !== want.ch) begin
            report($sformatf("char_out 8'h%02h, wanted 8'h%02h", ch, want.ch));
         end
         if (last !== want.last) begin
            report($sformatf("last %0b, wanted %0b on char 8'h%02h", last, want.last, want.ch));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;

   // Idling controls, set per phase by the stimulus process
   bit   send_steady = 1'b0;
   bit   take_steady = 1'b0;
   int   hold_off    = 0;
   int   long_holds  = 0;

   text_scoreboard texts = new();

   itoa_req_if req_bus ();
   itoa_rsp_if rsp_bus ();

   integer_to_ascii_base_n_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d characters still awaited",
                  cycle_count, texts.awaited.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Request monitor: a number is predicted at the edge its beat is taken
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         texts.note_request(req_bus.value, req_bus.radix, req_bus.format_flags);
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         texts.check_char(rsp_bus.char_out, rsp_bus.last);
      end
   end

   // Response side: random stall before each beat, plus the odd long hold-off
   // requested by the stimulus process. Only one ready update per edge.
   initial begin
      int pause;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pause = take_steady ? 0 : $urandom_range(0, 14);
         if (hold_off > 0) begin
            pause    = pause + hold_off;
            hold_off = 0;
            long_holds++;
         end
         if (pause > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Offer one number; returns once the unit has taken the beat. valid stays
   // high into the next call when that one draws no gap.
   task send_number(logic [VALUE_FIELD_BITS-1:0] value, logic [RADIX_BITS-1:0] radix,
                    logic [FLAGS_BITS-1:0] flags);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.value        <= value;
      req_bus.radix        <= radix;
      req_bus.format_flags <= flags;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // one edge first, so the request monitor has noted the last beat taken
   task wait_drained();
      @(posedge clock);
      while (texts.awaited.size() != 0) @(posedge clock);
   endtask

   // Mix of shapes so short, long, negative and edge-of-range numbers all turn up
   function automatic logic [VALUE_FIELD_BITS-1:0] random_value();
      logic [VALUE_FIELD_BITS-1:0] near;
      near = VALUE_FIELD_BITS'($urandom_range(0, 300));
      unique case ($urandom_range(0, 5))
         0: return $urandom;
         1: return near;
         2: return -near;
         3: return 32'h8000_0000 + near;
         4: return 32'h7FFF_FFFF - near;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [RADIX_BITS-1:0] random_radix();
      // mostly legal radices, now and then anything the field can hold
      if ($urandom_range(0, 7) == 0) begin
         return RADIX_BITS'($urandom_range(0, 31));
      end
      return RADIX_BITS'($urandom_range(2, 16));
   endfunction

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.value        <= '0;
      req_bus.radix        <= '0;
      req_bus.format_flags <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero, extremes, clamped radices, both letter cases, sign handling
      send_number(32'd0,          5'd10, FMT_SIGNED_UPPER);
      send_number(32'd0,          5'd2,  FMT_UNSIGNED_LOWER);
      send_number(32'hFFFF_FFFF,  5'd2,  FMT_UNSIGNED_UPPER);   // longest unsigned text
      send_number(32'h8000_0000,  5'd2,  FMT_SIGNED_UPPER);     // most negative, binary
      send_number(32'h8000_0000,  5'd10, FMT_SIGNED_LOWER);
      send_number(32'h8000_0000,  5'd16, FMT_SIGNED_UPPER);
      send_number(32'h7FFF_FFFF,  5'd10, FMT_SIGNED_UPPER);
      send_number(32'hFFFF_FFFF,  5'd10, FMT_SIGNED_UPPER);     // minus one
      send_number(32'hFFFF_FFFF,  5'd16, FMT_UNSIGNED_LOWER);
      send_number(32'hDEAD_BEEF,  5'd16, FMT_UNSIGNED_UPPER);
      send_number(32'hDEAD_BEEF,  5'd16, FMT_UNSIGNED_LOWER);
      send_number(32'hDEAD_BEEF,  5'd16, FMT_SIGNED_LOWER);
      send_number(32'hABCD_EF01,  5'd16, FMT_SIGNED_UPPER);
      send_number(32'd255,        5'd0,  FMT_SIGNED_UPPER);     // radix below range
      send_number(32'd255,        5'd1,  FMT_UNSIGNED_UPPER);
      send_number(32'h0000_FACE,  5'd17, FMT_SIGNED_LOWER);     // radix above range
      send_number(32'h0000_FACE,  5'd31, FMT_UNSIGNED_UPPER);
      send_number(32'd1,          5'd2,  FMT_SIGNED_UPPER);
      send_number(32'd15,         5'd16, FMT_SIGNED_LOWER);
      send_number(32'd16,         5'd16, FMT_SIGNED_UPPER);
      send_number(32'd35,         5'd3,  FMT_SIGNED_UPPER);
      send_number(32'd12345,      5'd7,  FMT_UNSIGNED_UPPER);
      send_number(32'hFFFF_FF85,  5'd13, FMT_SIGNED_LOWER);
      send_number(32'h5555_5555,  5'd15, FMT_UNSIGNED_LOWER);
      req_bus.valid <= 1'b0;
      wait_drained();

      // Random phases with changing idling; phase 1 runs flat out on both sides
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
         take_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
         // long output hold while numbers keep coming, so the request side backs up
         if (phase == 3 || phase == 6) begin
            hold_off = LONG_HOLD;
         end
         for (int n = 0; n < PHASE_NUMBERS; n++) begin
            send_number(random_value(), random_radix(), FLAGS_BITS'($urandom_range(0, 3)));
         end
         // sender goes quiet until all text of this phase is out
         if (phase == 4) begin
            req_bus.valid <= 1'b0;
            wait_drained();
         end
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d numbers converted, %0d characters checked, %0d mismatches",
               texts.numbers_noted, texts.chars_checked, texts.mismatches);
      $display("%0d negative, longest text %0d characters, %0d long output holds",
               texts.negatives_noted, texts.longest_text, long_holds);
      if (texts.mismatches == 0 && texts.awaited.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
